// ===== rtl/deq_pkg.sv =====
// Package for the double-ended queue: operation and status codes and the
// control word that the top level broadcasts to every storage cell.
// No dependencies.
`default_nettype none

package deq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried by the kind field.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // What every cell does in a cycle.
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD       = 3'd0;
  localparam cell_op_t CELL_SHIFT_BACK = 3'd1; // take the left neighbor's entry
  localparam cell_op_t CELL_SHIFT_FRNT = 3'd2; // take the right neighbor's entry
  localparam cell_op_t CELL_FILL_TAIL  = 3'd3; // first empty cell stores the value
  localparam cell_op_t CELL_DROP_TAIL  = 3'd4; // last occupied cell empties
  localparam cell_op_t CELL_CLEAR      = 3'd5;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] push_value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/deq_cell.sv =====
// One storage cell of the double-ended queue chain.
// Depends on deq_pkg for the cell control word.
`default_nettype none

module deq_cell (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  deq_pkg::cell_ctrl_t    ctrl,
  input  wire  [deq_pkg::DATA_W-1:0]   left_data,
  input  wire                          left_valid,
  input  wire  [deq_pkg::DATA_W-1:0]   right_data,
  input  wire                          right_valid,
  output logic [deq_pkg::DATA_W-1:0]   data,
  output logic                         valid
);
  import deq_pkg::*;

  // Occupancy is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_SHIFT_BACK: valid <= left_valid;
        CELL_SHIFT_FRNT: valid <= right_valid;
        CELL_FILL_TAIL: begin
          if (!valid && left_valid) valid <= 1'b1;
        end
        CELL_DROP_TAIL: begin
          if (valid && !right_valid) valid <= 1'b0;
        end
        CELL_CLEAR: valid <= 1'b0;
        default: valid <= valid;
      endcase
    end
  end

  // The stored value itself needs no reset.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_SHIFT_BACK: data <= left_data;
      CELL_SHIFT_FRNT: data <= right_data;
      CELL_FILL_TAIL: begin
        if (!valid && left_valid) data <= ctrl.push_value;
      end
      default: data <= data;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: a chain of DEPTH storage cells with
// the front at cell 0, plus the operation decode and the result register.
// Depends on deq_pkg and deq_cell.
`default_nettype none

// Channel   Handshake             Fields
// request   req_valid/req_ready   kind, push_value
// response  rsp_valid/rsp_ready   popped_value, status, count
//
// Every accepted item produces exactly one response item, registered and presented in the cycle after acceptance.
// A new item is taken every cycle as long as the response register is empty
// or is being drained in the same cycle; the single response register sets
// this rate of one item per cycle.
// Reset empties all cells and the response register; the stored values
// themselves are not cleared. A stalled response holds off new requests.
//
// The cells form a shift chain: push front and pop front move every entry
// one cell, push back fills the first empty cell, and pop back empties the
// last occupied cell. Occupancy is therefore always a run of valid cells
// starting at cell 0.

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            req_valid,
  output logic                           req_ready,
  input  wire  [deq_pkg::KIND_W-1:0]     kind,
  input  wire  signed [deq_pkg::DATA_W-1:0] push_value,
  output logic                           rsp_valid,
  input  wire                            rsp_ready,
  output logic signed [deq_pkg::DATA_W-1:0] popped_value,
  output logic [deq_pkg::STATUS_W-1:0]   status,
  output logic [deq_pkg::COUNT_W-1:0]    count
);
  import deq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Cell contents and the neighbor views, extended by one position at each
  // end so that every cell sees a left and a right neighbor.
  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic [DATA_W-1:0] left_data  [DEPTH];
  logic              left_valid [DEPTH];
  logic [DATA_W-1:0] right_data [DEPTH];
  logic              right_valid[DEPTH];

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              is_empty;
  logic              is_full;
  logic [DATA_W-1:0] back_data;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  held_next;
  logic [DATA_W-1:0] popped_next;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W+COUNT_W-1:0] held_wide;

  assign accept    = req_valid && req_ready;
  assign req_ready = !rsp_valid || rsp_ready;
  assign is_empty  = !cell_valid[0];
  assign is_full   = cell_valid[DEPTH-1];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        // The push value enters at the front; the front's left is always
        // occupied so that the first empty cell test works at cell 0.
        assign left_data[gi]  = ctrl.push_value;
        assign left_valid[gi] = 1'b1;
      end else begin : g_mid_left
        assign left_data[gi]  = cell_data[gi-1];
        assign left_valid[gi] = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_data[gi]  = '0;
        assign right_valid[gi] = 1'b0;
      end else begin : g_mid_right
        assign right_data[gi]  = cell_data[gi+1];
        assign right_valid[gi] = cell_valid[gi+1];
      end

      deq_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_data   (left_data[gi]),
        .left_valid  (left_valid[gi]),
        .right_data  (right_data[gi]),
        .right_valid (right_valid[gi]),
        .data        (cell_data[gi]),
        .valid       (cell_valid[gi])
      );
    end
  endgenerate

  // The back entry is the one occupied cell whose right neighbor is empty;
  // exactly one cell matches when the queue holds anything.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && !right_valid[i]) back_data = back_data | cell_data[i];
    end
  end

  // Decode the request into the cell command and the response fields.
  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.push_value = push_value;
    held_next       = held;
    popped_next     = '0;
    status_next     = STATUS_DONE;
    if (accept) begin
      priority if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
        if (is_full) begin
          status_next = STATUS_FULL;
        end else begin
          ctrl.op   = (kind == KIND_PUSH_FRONT) ? CELL_SHIFT_BACK : CELL_FILL_TAIL;
          held_next = held + 1'b1;
        end
      end else if (kind == KIND_POP_FRONT || kind == KIND_POP_BACK) begin
        if (is_empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          ctrl.op     = (kind == KIND_POP_FRONT) ? CELL_SHIFT_FRNT : CELL_DROP_TAIL;
          popped_next = (kind == KIND_POP_FRONT) ? cell_data[0] : back_data;
          held_next   = held - 1'b1;
        end
      end else if (kind == KIND_CLEAR) begin
        ctrl.op   = CELL_CLEAR;
        held_next = '0;
      end else begin
        // Codes without meaning leave the queue alone and report done.
        ctrl.op = CELL_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      held <= held_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The count field is five bits wide and wraps for deeper queues.
  assign held_wide = {{COUNT_W{1'b0}}, held_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= popped_next;
      status       <= status_next;
      count        <= held_wide[COUNT_W-1:0];
    end
  end

  // Occupancy flags packed for the checks below.
  logic [DEPTH-1:0] occ;
  always_comb begin
    for (int i = 0; i < DEPTH; i++) occ[i] = cell_valid[i];
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == held)
    else $error("held count differs from the number of occupied cells");

  a_no_holes: assert property (@(posedge clk) disable iff (rst)
    ((occ >> 1) & ~occ) == '0)
    else $error("occupied cells do not form a run from the front");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_CLEAR |=> held == '0 && !cell_valid[0])
    else $error("clear left entries in the queue");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STATUS_DONE |-> popped_value == '0)
    else $error("failed operation returned a nonzero value");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (rst)
    accept && is_full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK)
    |=> $stable(held))
    else $error("push on a full queue changed the count");

endmodule

`default_nettype wire

// ===== tb/sv/double_ended_queue_check.sv =====
// Checker for the double-ended queue: watches both channels, keeps its own
// copy of the ring store and compares every response item with its prediction.
// Depends on deq_pkg.
`timescale 1ns / 100ps

module double_ended_queue_check
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       req_valid,
  input  wire                       req_ready,
  input  wire  [KIND_W-1:0]         kind,
  input  wire  signed [DATA_W-1:0]  push_value,
  input  wire                       rsp_valid,
  input  wire                       rsp_ready,
  input  wire  signed [DATA_W-1:0]  popped_value,
  input  wire  [STATUS_W-1:0]       status,
  input  wire  [COUNT_W-1:0]        count,
  output int                        fail_count,
  output int                        pending
);

  localparam int SLOTS = DEPTH;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
  } deq_result_t;

  logic signed [DATA_W-1:0] ring_store [SLOTS];
  int                       head_slot;
  int                       fill_level;
  deq_result_t              owed_results [$];

  // Applies one operation to the shadow queue and returns the response it causes.
  function automatic deq_result_t apply_operation(input logic [KIND_W-1:0] op,
                                                  input logic signed [DATA_W-1:0] value);
    deq_result_t res;
    res.popped_value = '0;
    res.status       = STATUS_DONE;
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (fill_level >= SLOTS) begin
          res.status = STATUS_FULL;
        end else if (op == KIND_PUSH_FRONT) begin
          head_slot = (head_slot + SLOTS - 1) % SLOTS;
          ring_store[head_slot] = value;
          fill_level++;
        end else begin
          ring_store[(head_slot + fill_level) % SLOTS] = value;
          fill_level++;
        end
      end
      KIND_POP_FRONT: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped_value = ring_store[head_slot];
          head_slot = (head_slot + 1) % SLOTS;
          fill_level--;
        end
      end
      KIND_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped_value = ring_store[(head_slot + fill_level - 1) % SLOTS];
          fill_level--;
        end
      end
      KIND_CLEAR: begin
        head_slot  = 0;
        fill_level = 0;
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(fill_level);
    return res;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    head_slot  = 0;
    fill_level = 0;
    for (int i = 0; i < SLOTS; i++) ring_store[i] = '0;
  end

  always @(posedge clk) begin
    deq_result_t want;
    if (rst) begin
      head_slot  = 0;
      fill_level = 0;
      owed_results.delete();
    end else begin
      // The response drained at this edge always belongs to an earlier request.
      if (rsp_valid && rsp_ready) begin
        if (owed_results.size() == 0) begin
          $error("response item with no request outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, actual %0d", want.popped_value, popped_value);
            fail_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        owed_results.push_back(apply_operation(kind, push_value));
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== tb/sv/double_ended_queue_test.sv =====
// Top of the double-ended queue testbench: clock, reset, request and response
// stimulus, watchdog and verdict. Depends on deq_pkg, double_ended_queue and
// double_ended_queue_check.
`timescale 1ns / 100ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          HOLD_CYCLES = 40;   // long receiver hold-off
  localparam int          STALL_LIMIT = 1000; // cycles without any handshake
  localparam int          PHASE_ITEMS = 350;

  logic                      clk;
  logic                      rst;
  logic                      req_valid;
  logic                      req_ready;
  logic [KIND_W-1:0]         kind;
  logic signed [DATA_W-1:0]  push_value;
  logic                      rsp_valid;
  logic                      rsp_ready;
  logic signed [DATA_W-1:0]  popped_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        count;

  int fail_count;
  int pending;

  // Percentages of cycles in which the sender idles or the receiver stalls.
  int send_idle_pct;
  int stall_pct;
  // Set by the stimulus to ask the receiver process for one long hold-off.
  bit hold_request;

  // Tallies for the closing summary.
  int n_push;
  int n_pop;
  int n_clear;
  int n_other;
  int idle_cycles;

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .push_value   (push_value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .popped_value (popped_value),
    .status       (status),
    .count        (count)
  );

  double_ended_queue_check #(
    .DEPTH(DEPTH)
  ) i_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .push_value   (push_value),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .popped_value (popped_value),
    .status       (status),
    .count        (count),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver decides its ready at every falling edge. When a long hold-off
  // is requested, ready is held low through the hold-off so that the single
  // response register fills and the block stalls the request channel.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // The watchdog ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one item. Idle gaps are inserted before it at the current rate; the
  // task returns at the rising edge at which the item was accepted.
  task automatic send_item(input logic [KIND_W-1:0] op, input logic signed [DATA_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid  <= 1'b1;
    kind       <= op;
    push_value <= value;
    case (op)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: n_push++;
      KIND_POP_FRONT, KIND_POP_BACK:   n_pop++;
      KIND_CLEAR:                      n_clear++;
      default:                         n_other++;
    endcase
    do @(posedge clk); while (!req_ready);
  endtask

  // Drops valid and waits until every outstanding response has been drained.
  task automatic drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly random values, with the extremes of the field mixed in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random operations in bursts: push-heavy bursts run the queue into full,
  // pop-heavy bursts run it dry, balanced bursts wander in between. A few
  // clears and undefined kinds are mixed in as noise.
  task automatic random_phase(input int n_items, input bit with_hold);
    int mode;
    int burst_left;
    int push_pct;
    int r;
    logic [KIND_W-1:0] op;
    burst_left = 0;
    mode       = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        mode       = $urandom_range(2);
        burst_left = $urandom_range(10, 40);
      end
      burst_left--;
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      r = $urandom_range(99);
      if (r < 2) begin
        op = KIND_CLEAR;
      end else if (r < 4) begin
        op = KIND_W'($urandom_range(KIND_CLEAR + 1, 7));
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
      end
      send_item(op, pick_value());
      // Halfway through, the receiver goes quiet while the sender keeps going.
      if (with_hold && i == n_items / 2) hold_request = 1'b1;
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    kind          = KIND_PUSH_FRONT;
    push_value    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    n_push        = 0;
    n_pop         = 0;
    n_clear       = 0;
    n_other       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: pops on an empty queue, the undefined kinds, a fill to
    // the limit with extreme values, pushes at both ends on a full queue,
    // pops at both ends, then a clear and a pop right after it.
    send_item(KIND_POP_FRONT, pick_value());
    send_item(KIND_POP_BACK, pick_value());
    send_item(3'd5, $urandom);
    send_item(3'd6, $urandom);
    send_item(3'd7, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                (i == 0) ? 32'sh8000_0000 : (i == 1) ? 32'sh7FFF_FFFF :
                (i == 2) ? -32'sd1 : (i == 3) ? 32'sd0 : $urandom);
    end
    send_item(KIND_PUSH_FRONT, pick_value());
    send_item(KIND_PUSH_BACK, pick_value());
    send_item(KIND_POP_FRONT, pick_value());
    send_item(KIND_POP_BACK, pick_value());
    send_item(KIND_CLEAR, pick_value());
    send_item(KIND_POP_FRONT, pick_value());
    // The sender pauses here until every response has come back.
    drain_responses();

    // Random part in five phases with different idling, each ending with a full drain.
    random_phase(PHASE_ITEMS, 1'b1);
    drain_responses();
    send_idle_pct = 57;
    random_phase(PHASE_ITEMS, 1'b0);
    drain_responses();
    send_idle_pct = 0;
    stall_pct     = 57;
    random_phase(PHASE_ITEMS, 1'b0);
    drain_responses();
    send_idle_pct = 37;
    stall_pct     = 37;
    random_phase(PHASE_ITEMS, 1'b1);
    drain_responses();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_phase(PHASE_ITEMS, 1'b0);
    drain_responses();

    // Let the response register settle before the verdict.
    repeat (4) @(posedge clk);
    $display("Covered %0d items: %0d pushes, %0d pops, %0d clears, %0d undefined kinds,",
             n_push + n_pop + n_clear + n_other, n_push, n_pop, n_clear, n_other);
    $display("over phases without idling, with sender gaps, receiver stalls and both.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
